FILE: design/double_hash_table_engine_defines.svh
// Assertion macros for the double-hash table engine.
`ifndef DOUBLE_HASH_TABLE_ENGINE_DEFINES_SVH
`define DOUBLE_HASH_TABLE_ENGINE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DHTE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DHTE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/dhte_pkg.sv
// Shared constants, codes and types of the double-hash table engine.
`default_nettype none

package dhte_pkg;

    // TABLE_SIZE must be a power of two: the hash reduces by masking.
    localparam int TABLE_SIZE = 256;
    localparam int KEY_BYTES  = 10;

    localparam int IDX_W      = $clog2(TABLE_SIZE);
    localparam int CNT_W      = $clog2(TABLE_SIZE + 1);
    localparam int BYTE_CNT_W = $clog2(KEY_BYTES);
    localparam int LOAD_LIMIT = (3 * TABLE_SIZE) / 4;

    localparam int ACT_W  = 2;
    localparam int KEY_W  = 40;
    localparam int KEY_TOT_W = 8 * KEY_BYTES;
    localparam int VAL_W  = 31;
    localparam int STAT_W = 3;

    localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd0;
    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
    localparam logic [ACT_W-1:0] ACT_DELETE = 2'd2;
    localparam logic [ACT_W-1:0] ACT_SPARE  = 2'd3;

    localparam logic [STAT_W-1:0] ST_FOUND     = 3'd0;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd1;
    localparam logic [STAT_W-1:0] ST_UPDATED   = 3'd2;
    localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HASH,
        S_READ,
        S_CHECK,
        S_COMMIT
    } state_t;

    typedef struct packed {
        logic [KEY_W-1:0] key_front;
        logic [KEY_W-1:0] key_back;
        logic [VAL_W-1:0] value;
    } slot_t;

    typedef struct packed {
        logic             done;
        logic [IDX_W-1:0] pos;
        logic [IDX_W-1:0] step;
    } hash_res_t;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             rd_en;
        logic             kill;
        logic             wr_en;
        logic [IDX_W-1:0] wr_idx;
        logic             mark_live;
    } store_cmd_t;

    typedef struct packed {
        logic occupied;
        logic live;
    } slot_flags_t;

endpackage

`default_nettype wire

FILE: design/dhte_if.sv
// Request and response channel interfaces of the double-hash table engine.
`default_nettype none

interface dhte_req_if;
    import dhte_pkg::*;

    logic             valid;
    logic             ready;
    logic [ACT_W-1:0] action;
    logic [KEY_W-1:0] key_front;
    logic [KEY_W-1:0] key_back;
    logic [VAL_W-1:0] new_value;

    modport source (output valid, action, key_front, key_back, new_value, input ready);
    modport sink   (input valid, action, key_front, key_back, new_value, output ready);
endinterface

interface dhte_rsp_if;
    import dhte_pkg::*;

    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [VAL_W-1:0]  found_value;
    logic [CNT_W-1:0]  live_entries;

    modport source (output valid, status, found_value, live_entries, input ready);
    modport sink   (input valid, status, found_value, live_entries, output ready);
endinterface

`default_nettype wire

FILE: design/dhte_hash.sv
// Byte-serial hash unit: start slot and probe step, one key byte per cycle.
`default_nettype none

module dhte_hash (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [dhte_pkg::KEY_W-1:0]  key_front,
    input  wire logic [dhte_pkg::KEY_W-1:0]  key_back,
    output dhte_pkg::hash_res_t              res
);
    import dhte_pkg::*;

    logic [KEY_TOT_W-1:0]  key_sr_reg;
    logic [IDX_W-1:0]      h_pos_reg;
    logic [IDX_W-1:0]      h_step_reg;
    logic [BYTE_CNT_W-1:0] cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [IDX_W-1:0]      byte_mod;

    // (size-1)*h == -h and (size+1)*h == h modulo a power-of-two size
    assign byte_mod = IDX_W'(key_sr_reg[KEY_TOT_W-1 -: 8]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == BYTE_CNT_W'(KEY_BYTES - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            key_sr_reg <= {key_front, key_back};
            h_pos_reg  <= '0;
            h_step_reg <= '0;
        end
        else if (busy_reg)
        begin
            key_sr_reg <= {key_sr_reg[KEY_TOT_W-9:0], 8'h00};
            h_pos_reg  <= byte_mod - h_pos_reg;
            h_step_reg <= h_step_reg + byte_mod;
        end
    end

    assign res.done = done_reg;
    assign res.pos  = {h_pos_reg[IDX_W-2:0], 1'b1};
    assign res.step = {h_step_reg[IDX_W-2:0], 1'b1};

endmodule

`default_nettype wire

FILE: design/dhte_store.sv
// Slot store: key/value memory with registered read, occupied and live flags.
`default_nettype none

module dhte_store (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire dhte_pkg::store_cmd_t cmd,
    input  wire dhte_pkg::slot_t   wr_data,
    output dhte_pkg::slot_t   rd_data,
    output dhte_pkg::slot_flags_t flags
);
    import dhte_pkg::*;

    slot_t                 mem [TABLE_SIZE];
    slot_t                 rd_data_reg;
    logic [TABLE_SIZE-1:0] occ_reg;
    logic [TABLE_SIZE-1:0] live_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[cmd.wr_idx] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[cmd.idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg  <= '0;
            live_reg <= '0;
        end
        else
        begin
            if (cmd.kill)
            begin
                live_reg[cmd.idx] <= 1'b0;
            end
            if (cmd.mark_live)
            begin
                occ_reg[cmd.wr_idx]  <= 1'b1;
                live_reg[cmd.wr_idx] <= 1'b1;
            end
        end
    end

    assign rd_data        = rd_data_reg;
    assign flags.occupied = occ_reg[cmd.idx];
    assign flags.live     = live_reg[cmd.idx];

endmodule

`default_nettype wire

FILE: design/double_hash_table_engine.sv
// Top level of the double-hash table engine: request sequencer and response register.
`default_nettype none
`include "double_hash_table_engine_defines.svh"

// Open-addressed table of 256 slots, 80-bit key, 31-bit value, double hashing.
// One request at a time: the key is hashed one byte per cycle, then each probe
// is a registered memory read (S_READ) followed by a compare (S_CHECK). The
// walk ends on a hit, on an unoccupied slot or once every slot has been
// compared; the engine then returns to idle, the only state that takes the next
// request. A result may wait in the output register while the next request is
// accepted. Inserts beyond 192 live entries, or with no free slot on the walk,
// return table full. Flags are cleared at reset.
module double_hash_table_engine (
    input  wire logic  clk,
    input  wire logic  rst_n,
    dhte_req_if.sink   req,
    dhte_rsp_if.source rsp
);
    import dhte_pkg::*;

    state_t state_reg, state_next;

    logic [ACT_W-1:0]  act_reg, act_next;
    logic [KEY_W-1:0]  kf_reg, kf_next;
    logic [KEY_W-1:0]  kb_reg, kb_next;
    logic [VAL_W-1:0]  nv_reg, nv_next;
    logic [IDX_W-1:0]  pos_reg, pos_next;
    logic [IDX_W-1:0]  step_reg, step_next;
    logic [CNT_W-1:0]  q_reg, q_next;
    logic              hit_reg, hit_next;
    logic              tomb_seen_reg, tomb_seen_next;
    logic [IDX_W-1:0]  tomb_reg, tomb_next;
    logic [CNT_W-1:0]  live_count_reg, live_count_next;

    logic              rsp_valid_reg, rsp_valid_next;
    logic [STAT_W-1:0] rsp_status_reg, rsp_status_next;
    logic [VAL_W-1:0]  rsp_value_reg, rsp_value_next;
    logic [CNT_W-1:0]  rsp_live_reg, rsp_live_next;

    logic        accept;
    logic        hash_start;
    hash_res_t   hash_res;
    store_cmd_t  store_cmd;
    slot_t       wr_data;
    slot_t       rd_data;
    slot_flags_t flags;

    logic probe_end;
    logic key_match;
    logic commit_go;
    logic do_update;
    logic do_insert;
    logic do_delete;
    logic at_limit;
    logic no_free;
    logic [STAT_W-1:0] status_res;
    logic [VAL_W-1:0]  value_res;

    dhte_hash u_hash (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (hash_start),
        .key_front (req.key_front),
        .key_back  (req.key_back),
        .res       (hash_res)
    );

    dhte_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (store_cmd),
        .wr_data (wr_data),
        .rd_data (rd_data),
        .flags   (flags)
    );

    assign accept    = req.valid && req.ready;
    assign probe_end = (q_reg == CNT_W'(TABLE_SIZE)) || !flags.occupied;
    assign key_match = flags.live && (rd_data.key_front == kf_reg)
                       && (rd_data.key_back == kb_reg);
    assign commit_go = (state_reg == S_COMMIT) && (!rsp_valid_reg || rsp.ready);
    assign at_limit  = live_count_reg >= CNT_W'(LOAD_LIMIT);
    assign no_free   = !tomb_seen_reg
                       && ((q_reg == CNT_W'(TABLE_SIZE)) || flags.occupied);

    // Outcome of the walk for the request held
    always_comb
    begin
        do_update  = 1'b0;
        do_insert  = 1'b0;
        do_delete  = 1'b0;
        status_res = ST_NOT_FOUND;
        value_res  = '0;
        case (act_reg) inside
            ACT_INSERT:
            begin
                if (hit_reg)
                begin
                    do_update  = 1'b1;
                    status_res = ST_UPDATED;
                end
                else if (at_limit || no_free)
                begin
                    status_res = ST_FULL;
                end
                else
                begin
                    do_insert  = 1'b1;
                    status_res = ST_INSERTED;
                end
            end
            ACT_DELETE:
            begin
                if (hit_reg)
                begin
                    do_delete  = 1'b1;
                    status_res = ST_FOUND;
                    value_res  = rd_data.value;
                end
            end
            ACT_LOOKUP, ACT_SPARE:
            begin
                if (hit_reg)
                begin
                    status_res = ST_FOUND;
                    value_res  = rd_data.value;
                end
            end
            default:
            begin
                status_res = ST_NOT_FOUND;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                if (hash_res.done)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = probe_end ? S_COMMIT : S_CHECK;
            end
            S_CHECK:
            begin
                state_next = key_match ? S_COMMIT : S_READ;
            end
            S_COMMIT:
            begin
                if (commit_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req.ready           = 1'b0;
        hash_start          = 1'b0;
        store_cmd.idx       = pos_reg;
        store_cmd.rd_en     = 1'b0;
        store_cmd.kill      = 1'b0;
        store_cmd.wr_en     = 1'b0;
        store_cmd.wr_idx    = pos_reg;
        store_cmd.mark_live = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req.ready  = 1'b1;
                hash_start = req.valid;
            end
            S_HASH:
            begin
            end
            S_READ:
            begin
                store_cmd.rd_en = !probe_end;
            end
            S_CHECK:
            begin
            end
            S_COMMIT:
            begin
                store_cmd.wr_en     = commit_go && (do_update || do_insert);
                store_cmd.wr_idx    = (do_insert && tomb_seen_reg) ? tomb_reg : pos_reg;
                store_cmd.mark_live = commit_go && do_insert;
                store_cmd.kill      = commit_go && do_delete;
            end
            default:
            begin
            end
        endcase
    end

    assign wr_data.key_front = kf_reg;
    assign wr_data.key_back  = kb_reg;
    assign wr_data.value     = nv_reg;

    always_comb
    begin
        act_next        = act_reg;
        kf_next         = kf_reg;
        kb_next         = kb_reg;
        nv_next         = nv_reg;
        pos_next        = pos_reg;
        step_next       = step_reg;
        q_next          = q_reg;
        hit_next        = hit_reg;
        tomb_seen_next  = tomb_seen_reg;
        tomb_next       = tomb_reg;
        live_count_next = live_count_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_status_next = rsp_status_reg;
        rsp_value_next  = rsp_value_reg;
        rsp_live_next   = rsp_live_reg;

        if (accept)
        begin
            act_next = req.action;
            kf_next  = req.key_front;
            kb_next  = req.key_back;
            nv_next  = req.new_value;
        end

        if ((state_reg == S_HASH) && hash_res.done)
        begin
            pos_next       = hash_res.pos;
            step_next      = hash_res.step;
            q_next         = '0;
            hit_next       = 1'b0;
            tomb_seen_next = 1'b0;
        end

        if (state_reg == S_CHECK)
        begin
            if (key_match)
            begin
                hit_next = 1'b1;
            end
            else
            begin
                if (!flags.live && !tomb_seen_reg)
                begin
                    tomb_seen_next = 1'b1;
                    tomb_next      = pos_reg;
                end
                pos_next = pos_reg + step_reg;
                q_next   = q_reg + 1'b1;
            end
        end

        if (commit_go)
        begin
            if (do_insert)
            begin
                live_count_next = live_count_reg + 1'b1;
            end
            else if (do_delete && (live_count_reg != '0))
            begin
                live_count_next = live_count_reg - 1'b1;
            end
            rsp_valid_next  = 1'b1;
            rsp_status_next = status_res;
            rsp_value_next  = value_res;
            rsp_live_next   = live_count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            live_count_reg <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            live_count_reg <= live_count_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        kf_reg         <= kf_next;
        kb_reg         <= kb_next;
        nv_reg         <= nv_next;
        pos_reg        <= pos_next;
        step_reg       <= step_next;
        q_reg          <= q_next;
        hit_reg        <= hit_next;
        tomb_seen_reg  <= tomb_seen_next;
        tomb_reg       <= tomb_next;
        rsp_status_reg <= rsp_status_next;
        rsp_value_reg  <= rsp_value_next;
        rsp_live_reg   <= rsp_live_next;
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = rsp_status_reg;
    assign rsp.found_value  = rsp_value_reg;
    assign rsp.live_entries = rsp_live_reg;

    `DHTE_ASSERT_SAME(a_load_limit, clk, rst_n, 1'b1,
        live_count_reg <= CNT_W'(LOAD_LIMIT), "live count above load limit")
    `DHTE_ASSERT_NEXT(a_accept_hash, clk, rst_n, accept,
        state_reg == S_HASH, "accepted item did not start hashing")
    `DHTE_ASSERT_SAME(a_probe_bound, clk, rst_n, state_reg == S_CHECK,
        q_reg < CNT_W'(TABLE_SIZE), "probe walk past table size")
    `DHTE_ASSERT_NEXT(a_count_stable, clk, rst_n, !commit_go,
        $stable(live_count_reg), "live count changed outside commit")

endmodule

`default_nettype wire

FILE: sim/table_checker.sv
// Checker for the double-hash table engine: shadow table, expected replies and comparison.
module table_checker
    import dhte_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    dhte_req_if        req,
    dhte_rsp_if        rsp,
    output int         mismatches,
    output int         outstanding
);

    typedef struct {
        logic [STAT_W-1:0] status;
        logic [VAL_W-1:0]  value;
        logic [CNT_W-1:0]  live;
    } table_reply_t;

    logic [KEY_W-1:0] stored_front [TABLE_SIZE];
    logic [KEY_W-1:0] stored_back  [TABLE_SIZE];
    logic [VAL_W-1:0] stored_value [TABLE_SIZE];
    bit               slot_used    [TABLE_SIZE];
    bit               slot_alive   [TABLE_SIZE];
    int               alive_count;
    int               peak_alive;
    int               status_tally [5];

    table_reply_t     expected_replies [$];

    function automatic int slot_hash(input logic [KEY_W-1:0] kf, input logic [KEY_W-1:0] kb,
                                     input longint mult);
        longint     h;
        logic [7:0] b;
        h = 0;
        for (int i = 0; i < KEY_BYTES; i++)
        begin
            b = (i < 5) ? kf[8*(4-i) +: 8] : kb[8*(9-i) +: 8];
            h = (mult * h + b) % TABLE_SIZE;
        end
        return int'((2 * h + 1) % TABLE_SIZE);
    endfunction

    function automatic table_reply_t apply_request(input logic [ACT_W-1:0] act,
                                                   input logic [KEY_W-1:0] kf,
                                                   input logic [KEY_W-1:0] kb,
                                                   input logic [VAL_W-1:0] nv);
        table_reply_t r;
        int           pos;
        int           stride;
        int           probes;
        int           tomb_idx;
        int           dst;
        bit           hit;
        bit           tomb_seen;
        pos       = slot_hash(kf, kb, TABLE_SIZE - 1);
        stride    = slot_hash(kf, kb, TABLE_SIZE + 1);
        probes    = 0;
        tomb_idx  = 0;
        hit       = 1'b0;
        tomb_seen = 1'b0;
        r.status  = ST_NOT_FOUND;
        r.value   = '0;

        while (!hit && probes < TABLE_SIZE && slot_used[pos])
        begin
            if (slot_alive[pos] && stored_front[pos] == kf && stored_back[pos] == kb)
                hit = 1'b1;
            else
            begin
                if (!slot_alive[pos] && !tomb_seen)
                begin
                    tomb_seen = 1'b1;
                    tomb_idx  = pos;
                end
                pos = (pos + stride) % TABLE_SIZE;
                probes++;
            end
        end

        case (act)
            ACT_INSERT:
            begin
                if (hit)
                begin
                    stored_value[pos] = nv;
                    r.status = ST_UPDATED;
                end
                else if (alive_count + 1 > LOAD_LIMIT)
                    r.status = ST_FULL;
                else if (!tomb_seen && (probes >= TABLE_SIZE || slot_used[pos]))
                    r.status = ST_FULL;
                else
                begin
                    dst = tomb_seen ? tomb_idx : pos;
                    stored_front[dst] = kf;
                    stored_back[dst]  = kb;
                    stored_value[dst] = nv;
                    slot_used[dst]    = 1'b1;
                    slot_alive[dst]   = 1'b1;
                    alive_count++;
                    r.status = ST_INSERTED;
                end
            end
            ACT_DELETE:
            begin
                if (hit)
                begin
                    slot_alive[pos] = 1'b0;
                    if (alive_count > 0)
                        alive_count--;
                    r.value  = stored_value[pos];
                    r.status = ST_FOUND;
                end
            end
            default:
            begin
                if (hit)
                begin
                    r.value  = stored_value[pos];
                    r.status = ST_FOUND;
                end
            end
        endcase

        if (alive_count > peak_alive)
            peak_alive = alive_count;
        r.live = alive_count[CNT_W-1:0];
        return r;
    endfunction

    task automatic report_coverage();
        $display("Replies: found %0d, not found %0d, updated %0d, inserted %0d, full %0d; peak live %0d",
                 status_tally[ST_FOUND], status_tally[ST_NOT_FOUND], status_tally[ST_UPDATED],
                 status_tally[ST_INSERTED], status_tally[ST_FULL], peak_alive);
    endtask

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
        alive_count = 0;
        peak_alive  = 0;
        foreach (status_tally[i])
            status_tally[i] = 0;
    end

    always @(posedge clk)
    begin
        table_reply_t exp;
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_SIZE; i++)
            begin
                slot_used[i]  = 1'b0;
                slot_alive[i] = 1'b0;
            end
            alive_count = 0;
            expected_replies.delete();
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_replies.size() == 0)
                begin
                    $error("unexpected reply: status %0d, found_value %0d, live_entries %0d",
                           rsp.status, rsp.found_value, rsp.live_entries);
                    mismatches++;
                end
                else
                begin
                    exp = expected_replies.pop_front();
                    if (exp.status < 5)
                        status_tally[exp.status]++;
                    if (rsp.status !== exp.status)
                    begin
                        $error("status: expected %0d, got %0d", exp.status, rsp.status);
                        mismatches++;
                    end
                    if (rsp.found_value !== exp.value)
                    begin
                        $error("found_value: expected %0d, got %0d", exp.value, rsp.found_value);
                        mismatches++;
                    end
                    if (rsp.live_entries !== exp.live)
                    begin
                        $error("live_entries: expected %0d, got %0d", exp.live, rsp.live_entries);
                        mismatches++;
                    end
                end
            end
            if (req.valid && req.ready)
                expected_replies.push_back(apply_request(req.action, req.key_front,
                                                         req.key_back, req.new_value));
        end
        outstanding = expected_replies.size();
    end

endmodule

FILE: sim/testbench.sv
// Top of the double-hash table engine testbench: clock, reset, request stimulus and verdict.
module testbench;
    import dhte_pkg::*;

    localparam int POOL_KEYS    = 240;
    localparam int FILL_ITEMS   = 230;
    localparam int CHURN_ITEMS  = 350;
    localparam int HOLD_AT      = 350;
    localparam int HOLD_CYCLES  = 400;
    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 64;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   outstanding;
    int   sent;
    int   directed;
    int   replies_taken;
    int   quiet_cycles;
    bit   steady;

    logic [KEY_TOT_W-1:0] key_pool [POOL_KEYS];

    dhte_req_if req();
    dhte_rsp_if rsp();

    double_hash_table_engine dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    table_checker chk
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic send_request(input logic [ACT_W-1:0] act, input logic [KEY_W-1:0] kf,
                                input logic [KEY_W-1:0] kb, input logic [VAL_W-1:0] nv);
        @(negedge clk);
        while (!steady && $urandom_range(99) < 18)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid     <= 1'b1;
        req.action    <= act;
        req.key_front <= kf;
        req.key_back  <= kb;
        req.new_value <= nv;
        do
            @(posedge clk);
        while (!req.ready);
        sent++;
    endtask

    task automatic send_random_request();
        int                   roll;
        logic [ACT_W-1:0]     act;
        logic [KEY_TOT_W-1:0] key;
        roll = $urandom_range(99);
        if (roll < 30)
            act = ACT_LOOKUP;
        else if (roll < 60)
            act = ACT_INSERT;
        else if (roll < 93)
            act = ACT_DELETE;
        else
            act = ACT_SPARE;
        if ($urandom_range(19) == 0)
            key = KEY_TOT_W'({$urandom, $urandom, $urandom});
        else
            key = key_pool[$urandom_range(POOL_KEYS - 1)];
        send_request(act, key[KEY_TOT_W-1:KEY_W], key[KEY_W-1:0], VAL_W'($urandom));
    endtask

    // reply side: random stalls, plus one long hold-off to back the engine up
    initial
    begin
        bit hold_done;
        hold_done = 1'b0;
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!hold_done && replies_taken >= HOLD_AT)
            begin
                hold_done = 1'b1;
                rsp.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
                rsp.ready <= steady || $urandom_range(99) >= 18;
        end
    end

    always @(posedge clk)
    begin
        if (rsp.valid && rsp.ready)
            replies_taken++;
        if (rst_n)
        begin
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Timed out after %0d cycles without an item", quiet_cycles);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        int fill_next;
        sent          = 0;
        replies_taken = 0;
        quiet_cycles  = 0;
        fill_next     = 0;
        steady        = 1'b0;
        rst_n         = 1'b0;
        req.valid     = 1'b0;
        req.action    = ACT_LOOKUP;
        req.key_front = '0;
        req.key_back  = '0;
        req.new_value = '0;
        foreach (key_pool[i])
            key_pool[i] = KEY_TOT_W'({$urandom, $urandom, $urandom});
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // empty table, extreme keys and values
        send_request(ACT_LOOKUP, 40'h0, 40'h0, 31'h0);
        send_request(ACT_DELETE, 40'hFFFFFFFFFF, 40'hFFFFFFFFFF, 31'h0);
        send_request(ACT_INSERT, 40'h0, 40'h0, 31'h0);
        send_request(ACT_INSERT, 40'hFFFFFFFFFF, 40'hFFFFFFFFFF, 31'h7FFFFFFF);
        send_request(ACT_LOOKUP, 40'h0, 40'h0, 31'h7FFFFFFF);
        send_request(ACT_SPARE, 40'hFFFFFFFFFF, 40'hFFFFFFFFFF, 31'h0);
        send_request(ACT_INSERT, 40'hFFFFFFFFFF, 40'hFFFFFFFFFF, 31'h2AAAAAAA);
        send_request(ACT_LOOKUP, 40'hFFFFFFFFFF, 40'hFFFFFFFFFF, 31'h0);
        // tombstone handling
        send_request(ACT_DELETE, 40'h0, 40'h0, 31'h0);
        send_request(ACT_LOOKUP, 40'h0, 40'h0, 31'h0);
        send_request(ACT_DELETE, 40'h0, 40'h0, 31'h0);
        send_request(ACT_INSERT, 40'h0, 40'h0, 31'h55555555);
        // same start slot, different stride: bytes 8 and 9 moved together
        send_request(ACT_INSERT, 40'h0123456789, 40'hABCDEF1020, 31'd100);
        send_request(ACT_INSERT, 40'h0123456789, 40'hABCDEF1121, 31'd101);
        send_request(ACT_INSERT, 40'h0123456789, 40'hABCDEF1222, 31'd102);
        send_request(ACT_LOOKUP, 40'h0123456789, 40'hABCDEF1222, 31'd0);
        send_request(ACT_DELETE, 40'h0123456789, 40'hABCDEF1121, 31'd0);
        send_request(ACT_LOOKUP, 40'h0123456789, 40'hABCDEF1222, 31'd0);
        send_request(ACT_INSERT, 40'h0123456789, 40'hABCDEF1323, 31'd103);
        send_request(ACT_LOOKUP, 40'h0123456789, 40'hABCDEF1121, 31'd0);
        send_request(ACT_DELETE, 40'h0123456789, 40'hABCDEF1020, 31'd0);
        send_request(ACT_INSERT, 40'h0123456789, 40'hABCDEF1222, 31'd104);
        send_request(ACT_INSERT, 40'hAAAAAAAAAA, 40'h5555555555, 31'd1);
        directed = sent;

        // fill towards the load limit, then churn around it
        for (int n = 0; n < FILL_ITEMS; n++)
        begin
            steady = (n >= 60 && n < 160);
            if ($urandom_range(99) < 85 && fill_next < POOL_KEYS)
            begin
                send_request(ACT_INSERT, key_pool[fill_next][KEY_TOT_W-1:KEY_W],
                             key_pool[fill_next][KEY_W-1:0], VAL_W'($urandom));
                fill_next++;
            end
            else
                send_random_request();
        end
        steady = 1'b0;
        for (int n = 0; n < CHURN_ITEMS; n++)
            send_random_request();

        @(negedge clk);
        req.valid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Sent %0d requests (%0d directed) with one %0d-cycle reply hold-off",
                 sent, directed, HOLD_CYCLES);
        chk.report_coverage();
        if (mismatches == 0 && outstanding == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
